>>> hdl/fsif_pkg.sv
// ----------------------------------------------------------------------------
// Integer formatter package
// Shared constants, state and code types, and the command and status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package fsif_pkg;

  // Argument slot width and the depth of the digit store.
  localparam int SLOT_BITS  = 16;
  localparam int MAX_DIGITS = 22;

  // Widths used across the blocks; the digit index width follows from the store depth.
  localparam int VAL_W = 64;
  localparam int CNT_W = 7;
  localparam int DIG_W = $clog2(MAX_DIGITS);
  localparam int EXT_W = 4 * 32;
  localparam logic [VAL_W-1:0] SLOT_MASK = VAL_W'((65'(1) << SLOT_BITS) - 65'(1));

  // Characters that the parser recognises or emits.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_XU    = 8'h58;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_C     = 8'h63;

  // Digit glyphs, least significant value first.
  localparam logic [7:0] DIGIT_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef enum logic [2:0] {
    PH_TEXT, PH_PCT, PH_H, PH_L, PH_SPEC, PH_ARGS
  } phase_t;

  typedef enum logic [2:0] {
    LEN_DEF, LEN_HH, LEN_H, LEN_L, LEN_LL
  } len_t;

  typedef enum logic [2:0] {
    CV_NONE, CV_SDEC, CV_UDEC, CV_HEX, CV_OCT, CV_CHR
  } conv_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ONE, ST_LOAD, ST_DABBLE, ST_SCAN, ST_SIGN, ST_DIGIT
  } state_t;

  // Source of the next result loaded into the output register.
  typedef enum logic [2:0] {
    OS_NONE, OS_ONE, OS_PEND, OS_SIGN, OS_DIGIT
  } out_sel_t;

  typedef struct packed {
    conv_t      conv;
    logic [2:0] slots;
    logic       gather_clr;
    logic       gather_we;
    logic [1:0] gather_slot;
    logic       load;
    logic       step;
    logic       scan;
    logic       dig_dec;
    out_sel_t   out_sel;
    logic [7:0] one_char;
    logic       one_mis;
    logic       pend_we;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic cnt_zero;
    logic neg;
    logic top_zero;
  } dp_stat_t;

  // Width in bits of a gathered value, capped at the value register width.
  function automatic logic [CNT_W-1:0] total_bits(input logic [2:0] slots);
    int t;
    t = SLOT_BITS * int'(slots);
    if (t > VAL_W) t = VAL_W;
    return CNT_W'(t);
  endfunction

endpackage

>>> hdl/format_string_integer_formatter.sv
// ----------------------------------------------------------------------------
// Integer format-string formatter
// Top level: joins the parsing controller to the conversion datapath.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A format byte, a misplaced item, a slot
// word that does not complete an argument, or one that completes a character
// argument is handled in its accepting cycle, and any single result goes out
// through the output register. If that register is still occupied, the
// result waits in a pending slot and the input stalls until it can move on.
// A completed hex or octal argument passes through a load state and a digit
// scan state. A completed decimal argument adds, after the load, a
// shift-and-correct conversion of one bit per cycle over the gathered width
// and a closing pass. The characters then go out one per cycle, each also
// waiting for as long as the receiver holds the output back. The next item
// is accepted once the last character of an argument has been loaded into
// the output register. The digit store needs no clearing.
module format_string_integer_formatter
  import fsif_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_fmt_byte,
  input  logic [15:0] in_arg_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_last_of_run,
  output logic        out_misuse
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Parser and sequencer.
  fsif_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_fmt_byte (in_fmt_byte),
    .in_arg_word (in_arg_word),
    .stat        (stat),
    .cmd         (cmd)
  );

  // Gathering, conversion and output register.
  fsif_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_arg_word     (in_arg_word),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run),
    .out_misuse      (out_misuse)
  );

endmodule

>>> hdl/fsif_datapath.sv
// ----------------------------------------------------------------------------
// Integer formatter datapath
// Gathers argument slots, converts the value into digits and holds the
// output register together with a one-item pending result.
// ----------------------------------------------------------------------------
module fsif_datapath
  import fsif_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] in_arg_word,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [7:0]  out_char,
  output logic        out_last_of_run,
  output logic        out_misuse
);

  logic [VAL_W-1:0] value_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic [3:0]       digit_r [MAX_DIGITS];
  logic [DIG_W-1:0] top_r;
  logic [7:0]       pend_char_r;
  logic             pend_mis_r;
  logic             out_valid_r;
  logic [7:0]       out_char_r;
  logic             out_last_r;
  logic             out_mis_r;

  logic [VAL_W-1:0] word;
  logic [CNT_W-1:0] shift;
  logic [CNT_W-1:0] total;
  logic [VAL_W-1:0] mask;
  logic [VAL_W-1:0] v;
  logic             neg;
  logic [VAL_W-1:0] mag;
  logic [EXT_W-1:0] magx;
  logic [VAL_W-1:0] aligned;
  logic [3:0]       adj [MAX_DIGITS];
  logic [DIG_W-1:0] lead;
  logic             out_free;

  // Slot placement: a slot that lands beyond the value register is ignored.
  assign word  = VAL_W'(in_arg_word) & SLOT_MASK;
  assign shift = CNT_W'(SLOT_BITS * int'(cmd.gather_slot));

  // Masking, sign test and magnitude of the gathered value.
  assign total   = total_bits(cmd.slots);
  assign mask    = (total == CNT_W'(VAL_W)) ? '1 : ((VAL_W'(1) << total) - VAL_W'(1));
  assign v       = value_r & mask;
  assign neg     = (cmd.conv == CV_SDEC) && v[6'(total - CNT_W'(1))];
  assign mag     = neg ? ((~v + VAL_W'(1)) & mask) : v;
  assign magx    = EXT_W'(mag);
  assign aligned = mag << (CNT_W'(VAL_W) - total);

  // Add-three correction of each decimal digit ahead of the shift.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (digit_r[i] >= 4'd5) ? (digit_r[i] + 4'd3) : digit_r[i];
    end
  end

  // Highest digit that is not zero; the last one found wins.
  always_comb begin
    lead = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (digit_r[i] != 4'd0) lead = DIG_W'(i);
    end
  end

  // Value register and conversion counter.
  always_ff @(posedge clk) begin
    if (cmd.gather_clr) begin
      value_r <= '0;
    end else if (cmd.gather_we) begin
      if (shift < CNT_W'(VAL_W)) value_r <= value_r | (word << shift);
    end else if (cmd.load) begin
      value_r <= aligned;
      cnt_r   <= total;
      neg_r   <= neg;
    end else if (cmd.step) begin
      value_r <= value_r << 1;
      cnt_r   <= cnt_r - CNT_W'(1);
    end
  end

  // Digit store: loaded directly for hex and octal, shifted in for decimal.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        if (cmd.conv == CV_HEX) digit_r[i] <= magx[4*i +: 4];
        else if (cmd.conv == CV_OCT) digit_r[i] <= {1'b0, magx[3*i +: 3]};
        else digit_r[i] <= 4'd0;
      end
    end else if (cmd.step) begin
      digit_r[0] <= {adj[0][2:0], value_r[VAL_W-1]};
      for (int i = 1; i < MAX_DIGITS; i++) begin
        digit_r[i] <= {adj[i][2:0], adj[i-1][3]};
      end
    end
  end

  // Digit index: set by the scan, counted down as digits go out.
  always_ff @(posedge clk) begin
    if (cmd.scan) top_r <= lead;
    else if (cmd.dig_dec) top_r <= top_r - DIG_W'(1);
  end

  // Pending single result while the output register is still occupied.
  always_ff @(posedge clk) begin
    if (cmd.pend_we) begin
      pend_char_r <= cmd.one_char;
      pend_mis_r  <= cmd.one_mis;
    end
  end

  // Output register.
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_sel != OS_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.out_sel)
      OS_ONE: begin
        out_char_r <= cmd.one_char;
        out_last_r <= 1'b1;
        out_mis_r  <= cmd.one_mis;
      end
      OS_PEND: begin
        out_char_r <= pend_char_r;
        out_last_r <= 1'b1;
        out_mis_r  <= pend_mis_r;
      end
      OS_SIGN: begin
        out_char_r <= CH_MINUS;
        out_last_r <= 1'b0;
        out_mis_r  <= 1'b0;
      end
      OS_DIGIT: begin
        out_char_r <= DIGIT_CHARS[digit_r[top_r]];
        out_last_r <= (top_r == '0);
        out_mis_r  <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign stat.out_free = out_free;
  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.neg      = neg_r;
  assign stat.top_zero = (top_r == '0);

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_last_of_run = out_last_r;
  assign out_misuse      = out_mis_r;

endmodule

>>> hdl/fsif_ctrl.sv
// ----------------------------------------------------------------------------
// Integer formatter controller
// Parses the format stream, tracks argument gathering and sequences the
// conversion and the emission of characters.
// ----------------------------------------------------------------------------
module fsif_ctrl
  import fsif_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_fmt_byte,
  input  logic [15:0] in_arg_word,
  input  dp_stat_t    stat,
  output dp_cmd_t     cmd
);

  state_t     st_r, st_nxt;
  phase_t     phase_r, phase_nxt;
  len_t       len_r, len_nxt;
  conv_t      conv_r, conv_nxt;
  logic [2:0] needed_r, needed_nxt;
  logic [2:0] got_r, got_nxt;

  conv_t      spec_conv;
  logic [2:0] spec_slots;
  logic [2:0] got_sum;
  logic       one;
  logic       do_spec;
  logic       to_text;

  // Conversion letter decode and the slot count it would need.
  always_comb begin
    unique case (in_fmt_byte)
      CH_D, CH_I:       spec_conv = CV_SDEC;
      CH_U:             spec_conv = CV_UDEC;
      CH_X, CH_XU, CH_P: spec_conv = CV_HEX;
      CH_O:             spec_conv = CV_OCT;
      CH_C:             spec_conv = CV_CHR;
      default:          spec_conv = CV_NONE;
    endcase
    if (spec_conv == CV_CHR) spec_slots = 3'd1;
    else if (len_r == LEN_L) spec_slots = 3'd2;
    else if (len_r == LEN_LL) spec_slots = 3'd4;
    else spec_slots = 3'd1;
  end

  assign got_sum  = got_r + 3'd1;
  assign in_ready = (st_r == ST_IDLE);

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      phase_r  <= PH_TEXT;
      len_r    <= LEN_DEF;
      conv_r   <= CV_NONE;
      needed_r <= 3'd0;
      got_r    <= 3'd0;
    end else begin
      st_r     <= st_nxt;
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      conv_r   <= conv_nxt;
      needed_r <= needed_nxt;
      got_r    <= got_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    st_nxt     = st_r;
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    conv_nxt   = conv_r;
    needed_nxt = needed_r;
    got_nxt    = got_r;
    cmd        = '0;
    cmd.conv   = conv_r;
    cmd.slots  = needed_r;
    one        = 1'b0;
    do_spec    = 1'b0;
    to_text    = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind) begin
            // Argument slot word.
            if (phase_r != PH_ARGS) begin
              one         = 1'b1;
              cmd.one_mis = 1'b1;
            end else begin
              cmd.gather_we   = 1'b1;
              cmd.gather_slot = got_r[1:0];
              got_nxt         = got_sum;
              if (got_sum >= needed_r) begin
                phase_nxt = PH_TEXT;
                len_nxt   = LEN_DEF;
                got_nxt   = 3'd0;
                if (conv_r == CV_CHR) begin
                  one          = 1'b1;
                  cmd.one_char = in_arg_word[7:0];
                end else begin
                  st_nxt = ST_LOAD;
                end
              end
            end
          end else if (phase_r == PH_ARGS) begin
            // Format byte while arguments are awaited.
            one         = 1'b1;
            cmd.one_mis = 1'b1;
          end else if (in_fmt_byte == CH_NUL) begin
            to_text = 1'b1;
          end else begin
            unique case (phase_r)
              PH_TEXT: begin
                if (in_fmt_byte == CH_PCT) begin
                  phase_nxt = PH_PCT;
                end else begin
                  one          = 1'b1;
                  cmd.one_char = in_fmt_byte;
                end
              end
              PH_PCT: begin
                if (in_fmt_byte == CH_H) begin
                  len_nxt   = LEN_H;
                  phase_nxt = PH_H;
                end else if (in_fmt_byte == CH_L) begin
                  len_nxt   = LEN_L;
                  phase_nxt = PH_L;
                end else begin
                  do_spec = 1'b1;
                end
              end
              PH_H: begin
                if (in_fmt_byte == CH_H) begin
                  len_nxt   = LEN_HH;
                  phase_nxt = PH_SPEC;
                end else begin
                  do_spec = 1'b1;
                end
              end
              PH_L: begin
                if (in_fmt_byte == CH_L) begin
                  len_nxt   = LEN_LL;
                  phase_nxt = PH_SPEC;
                end else begin
                  do_spec = 1'b1;
                end
              end
              PH_SPEC: do_spec = 1'b1;
              default: to_text = 1'b1;
            endcase
          end

          // Conversion letter: start gathering, or finish the directive.
          if (do_spec) begin
            if (spec_conv != CV_NONE) begin
              conv_nxt       = spec_conv;
              needed_nxt     = spec_slots;
              got_nxt        = 3'd0;
              phase_nxt      = PH_ARGS;
              cmd.gather_clr = 1'b1;
            end else begin
              to_text = 1'b1;
              if (in_fmt_byte == CH_PCT) begin
                one          = 1'b1;
                cmd.one_char = CH_PCT;
              end
            end
          end

          if (to_text) begin
            phase_nxt  = PH_TEXT;
            len_nxt    = LEN_DEF;
            conv_nxt   = CV_NONE;
            needed_nxt = 3'd0;
            got_nxt    = 3'd0;
          end

          // A single result goes straight out, or waits in the pending slot.
          if (one) begin
            if (stat.out_free) begin
              cmd.out_sel = OS_ONE;
            end else begin
              cmd.pend_we = 1'b1;
              st_nxt      = ST_ONE;
            end
          end
        end
      end
      ST_ONE: begin
        if (stat.out_free) begin
          cmd.out_sel = OS_PEND;
          st_nxt      = ST_IDLE;
        end
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
        if (conv_r == CV_SDEC || conv_r == CV_UDEC) st_nxt = ST_DABBLE;
        else st_nxt = ST_SCAN;
      end
      ST_DABBLE: begin
        if (stat.cnt_zero) st_nxt = ST_SCAN;
        else cmd.step = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        st_nxt   = stat.neg ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (stat.out_free) begin
          cmd.out_sel = OS_SIGN;
          st_nxt      = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (stat.out_free) begin
          cmd.out_sel = OS_DIGIT;
          if (stat.top_zero) st_nxt = ST_IDLE;
          else cmd.dig_dec = 1'b1;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer format-string formatter testbench
// Drives format bytes and argument slot words into the formatter and checks
// every character that comes out against a cycle-free model of the parser
// and number conversion held in a small scoreboard. Both handshakes idle at
// random, the receiver once holds off long enough to stall the input, and
// the sender once waits until every expected character has arrived.
// ----------------------------------------------------------------------------
module tb_top;
  import fsif_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RANDOM_ITEMS  = 120;
  localparam int HOLD_CYCLES   = 300;
  localparam int END_CYCLES    = 200;
  localparam int LIMIT_CYCLES  = 800_000;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [7:0] ASCII_ZERO = "0";
  localparam logic [7:0] ASCII_A    = "A";
  localparam logic [7:0] SPEC_CHARS [8] = '{CH_D, CH_I, CH_U, CH_X, CH_XU, CH_P, CH_O, CH_C};

  // One character as the block emits it.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       mis;
  } fmt_char_t;

  // Parser and conversion model with the queue of characters still owed.
  class char_stream_checker;
    phase_t      phase;
    len_t        len_mode;
    conv_t       conv;
    int unsigned slots_needed;
    int unsigned slots_got;
    logic [63:0] value;
    fmt_char_t   expected_chars[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase        = PH_TEXT;
      len_mode     = LEN_DEF;
      conv         = CV_NONE;
      slots_needed = 0;
      slots_got    = 0;
      value        = '0;
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction

    function void owe(logic [7:0] ch, logic last, logic mis);
      fmt_char_t c;
      c.ch   = ch;
      c.last = last;
      c.mis  = mis;
      expected_chars.push_back(c);
    endfunction

    // A conversion letter either opens argument gathering or ends the spec.
    function void begin_args(conv_t kind);
      conv         = kind;
      slots_needed = 1;
      if (kind != CV_CHR) begin
        if (len_mode == LEN_L) slots_needed = 2;
        else if (len_mode == LEN_LL) slots_needed = 4;
      end
      slots_got = 0;
      value     = '0;
      phase     = PH_ARGS;
    endfunction

    function void take_spec(logic [7:0] c);
      case (c)
        CH_D, CH_I:        begin_args(CV_SDEC);
        CH_U:              begin_args(CV_UDEC);
        CH_X, CH_XU, CH_P: begin_args(CV_HEX);
        CH_O:              begin_args(CV_OCT);
        CH_C:              begin_args(CV_CHR);
        CH_PCT: begin
          clear_parse();
          owe(CH_PCT, 1'b1, 1'b0);
        end
        default:           clear_parse();
      endcase
    endfunction

    // Digits of the gathered value, most significant first, with a sign.
    function void owe_number();
      int unsigned width;
      int unsigned radix;
      logic [63:0] mask;
      logic [63:0] v;
      bit          neg;
      logic [3:0]  digits[$];
      width = SLOT_BITS * slots_needed;
      if (width >= 64) begin
        width = 64;
        mask  = '1;
      end else begin
        mask = (64'd1 << width) - 64'd1;
      end
      v   = value & mask;
      neg = (conv == CV_SDEC) && v[width-1];
      if (neg) v = (~v + 64'd1) & mask;
      radix = (conv == CV_HEX) ? 16 : (conv == CV_OCT) ? 8 : 10;
      do begin
        digits.push_back(4'(v % radix));
        v = v / radix;
      end while (v != 0 && digits.size() < MAX_DIGITS);
      if (neg) owe(CH_MINUS, 1'b0, 1'b0);
      for (int i = digits.size() - 1; i >= 0; i--) begin
        owe(digits[i] < 10 ? ASCII_ZERO + 8'(digits[i]) : ASCII_A + 8'(digits[i]) - 8'd10,
            i == 0, 1'b0);
      end
    endfunction

    // Works out the characters that one accepted item causes.
    function void note_item(logic kind, logic [7:0] fb, logic [15:0] aw);
      int unsigned shift;
      if (kind) begin
        if (phase != PH_ARGS) begin
          owe(8'h00, 1'b1, 1'b1);
          return;
        end
        shift = SLOT_BITS * slots_got;
        if (shift < 64) value |= (64'(aw) & ((64'd1 << SLOT_BITS) - 64'd1)) << shift;
        slots_got++;
        if (slots_got < slots_needed) return;
        if (conv == CV_CHR) owe(value[7:0], 1'b1, 1'b0);
        else owe_number();
        clear_parse();
        return;
      end
      if (phase == PH_ARGS) begin
        owe(8'h00, 1'b1, 1'b1);
        return;
      end
      if (fb == CH_NUL) begin
        clear_parse();
        return;
      end
      case (phase)
        PH_TEXT: begin
          if (fb == CH_PCT) phase = PH_PCT;
          else owe(fb, 1'b1, 1'b0);
        end
        PH_PCT: begin
          if (fb == CH_H) begin
            len_mode = LEN_H;
            phase    = PH_H;
          end else if (fb == CH_L) begin
            len_mode = LEN_L;
            phase    = PH_L;
          end else begin
            take_spec(fb);
          end
        end
        PH_H: begin
          if (fb == CH_H) begin
            len_mode = LEN_HH;
            phase    = PH_SPEC;
          end else begin
            take_spec(fb);
          end
        end
        PH_L: begin
          if (fb == CH_L) begin
            len_mode = LEN_LL;
            phase    = PH_SPEC;
          end else begin
            take_spec(fb);
          end
        end
        PH_SPEC: take_spec(fb);
        default: clear_parse();
      endcase
    endfunction

    // Compares one emitted character with the oldest one owed.
    function void check_char(logic [7:0] ch, logic last, logic mis);
      fmt_char_t want;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected character %h last %b misuse %b", $time, ch, last, mis);
        return;
      end
      want = expected_chars.pop_front();
      if (ch !== want.ch || last !== want.last || mis !== want.mis) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: mismatch: expected char %h last %b misuse %b, got char %h last %b misuse %b",
                   $time, want.ch, want.last, want.mis, ch, last, mis);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = 1'b0;
  logic [7:0]  in_fmt_byte = 8'h00;
  logic [15:0] in_arg_word = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_char;
  logic        out_last_of_run;
  logic        out_misuse;

  char_stream_checker sb = new();

  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned items_sent = 0;

  format_string_integer_formatter u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_fmt_byte     (in_fmt_byte),
    .in_arg_word     (in_arg_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run),
    .out_misuse      (out_misuse)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Idle stretch length: mostly none or short, now and then long.
  function automatic int unsigned idle_length(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 30);
  endfunction

  // Offers one item and waits until it is taken. Valid is left high so that
  // a following item can be offered without a gap.
  task automatic send_item(logic kind, logic [7:0] fb, logic [15:0] aw);
    int unsigned gap;
    gap = idle_length(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_fmt_byte <= fb;
    in_arg_word <= aw;
    do @(posedge clk); while (!in_ready);
    sb.note_item(kind, fb, aw);
    items_sent++;
  endtask

  // The field that the item kind ignores still carries random bits.
  task automatic send_byte(logic [7:0] b);
    send_item(1'b0, b, 16'($urandom_range(0, 65535)));
  endtask

  task automatic send_word(logic [15:0] w);
    send_item(1'b1, 8'($urandom_range(0, 255)), w);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Length prefix: 0 none, 1 h, 2 hh, 3 l, 4 ll.
  task automatic send_prefix(int unsigned lc);
    if (lc == 1 || lc == 2) send_byte(CH_H);
    if (lc == 2) send_byte(CH_H);
    if (lc >= 3) send_byte(CH_L);
    if (lc == 4) send_byte(CH_L);
  endtask

  // Argument words lean towards the sign boundary and the all-ones value.
  function automatic logic [15:0] pick_word(bit top);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (top && r < 25) begin
      case ($urandom_range(0, 2))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        default: return 16'hFFFF;
      endcase
    end
    if (r < 35) return 16'h0000;
    if (r < 45) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Every accepted character is checked as it leaves.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_char(out_char, out_last_of_run, out_misuse);
  end

  // Receiver: random stalls, and one long hold-off when asked for.
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req   = 1'b0;
        stall_left = 0;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = idle_length(rx_calm);
      end
    end
  end

  // Main stimulus: a directed opening, then random format sequences.
  initial begin : stimulus
    int unsigned start_count;
    int unsigned progress;
    int unsigned choice;
    int unsigned lc;
    int unsigned nslots;
    logic [7:0]  spec;
    logic [7:0]  b;
    bit          hold_issued;
    bit          drained;
    hold_issued = 1'b0;
    drained     = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Top byte value as plain text, and a word with no conversion open.
    send_byte(8'hFF);
    send_word(16'hFFFF);
    send_text("%%");
    // Most negative 64-bit value, with a format byte arriving mid-argument.
    send_text("%lld");
    send_word(16'h0000);
    send_word(16'h0000);
    send_byte("Z");
    send_word(16'h0000);
    send_word(16'h8000);
    // Largest octal value gives the longest run of digits.
    send_text("%llo");
    repeat (4) send_word(16'hFFFF);
    // Length prefix on a character conversion is ignored.
    send_text("%hc");
    send_word(16'h1241);
    // Unknown conversion, then a string end inside a spec.
    send_text("%s");
    send_text("%l");
    send_byte(CH_NUL);

    start_count = items_sent;
    progress    = 0;
    while (progress < RANDOM_ITEMS) begin
      // Long receiver hold-off early on, a quiet stretch later.
      if (!hold_issued && progress >= 40) begin
        hold_issued = 1'b1;
        hold_req    = 1'b1;
      end
      rx_calm = (progress >= 100 && progress < 125);
      tx_calm = rx_calm || hold_req;

      // Sender pause until every owed character is out.
      if (!drained && progress >= 85) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end

      choice = $urandom_range(0, 99);
      if (choice < 55) begin
        // Numeric or character conversion, now and then with a format byte between its slot words.
        lc   = $urandom_range(0, 4);
        spec = SPEC_CHARS[$urandom_range(0, 7)];
        send_byte(CH_PCT);
        send_prefix(lc);
        send_byte(spec);
        nslots = (spec == CH_C) ? 1 : (lc == 3) ? 2 : (lc == 4) ? 4 : 1;
        for (int i = 0; i < nslots; i++) begin
          if ($urandom_range(0, 19) == 0) send_byte(8'($urandom_range(1, 255)));
          send_word(pick_word(i == nslots - 1));
        end
      end else if (choice < 73) begin
        b = 8'($urandom_range(1, 255));
        if (b == CH_PCT) b = CH_MINUS;
        send_byte(b);
      end else if (choice < 80) begin
        send_byte(CH_PCT);
        send_prefix($urandom_range(0, 4));
        send_byte(CH_PCT);
      end else if (choice < 87) begin
        // Conversion letter that the parser does not know.
        send_byte(CH_PCT);
        send_prefix($urandom_range(0, 4));
        do b = 8'($urandom_range(1, 255));
        while (b inside {CH_D, CH_I, CH_U, CH_X, CH_XU, CH_P, CH_O, CH_C, CH_PCT, CH_H, CH_L});
        send_byte(b);
      end else if (choice < 93) begin
        send_byte(CH_PCT);
        send_prefix($urandom_range(0, 4));
        send_byte(CH_NUL);
      end else if (choice < 97) begin
        send_word(16'($urandom_range(0, 65535)));
      end else begin
        send_byte(CH_NUL);
      end
      progress = items_sent - start_count;
    end

    // Drain and let the block settle before the verdict.
    in_valid <= 1'b0;
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (END_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit, well above the slowest correct run.
  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
